>>> sv/isr_pkg.sv
package isr_pkg;

  // Fixed field widths of the stream words
  localparam int unsigned RadicandW = 64;
  localparam int unsigned RootW     = 32;

  // Handshake between neighboring cells: valid goes down the chain
  typedef struct packed {
    logic valid;
  } isr_fwd_t;

  // Ready goes up the chain
  typedef struct packed {
    logic ready;
  } isr_bwd_t;

endpackage

>>> sv/integer_square_root_unit.sv
// Channel   Dir  Width  Contents
// s_axis    in   64     tdata[63:0] radicand (low WIDTH bits used)
// m_axis    out  32     tdata[31:0] root = floor(sqrt(radicand))
//
// A chain of (WIDTH+1)/2 cells, one root bit per cell; one word is taken per
// cycle when the output side keeps up.
// The last cell is the output register; each cell fills when empty, so
// bubbles close up while the output is stalled.
// Reset clears only the valid bits of the cells.
module integer_square_root_unit
  import isr_pkg::*;
#(
  parameter int unsigned WIDTH = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [RadicandW-1:0] s_axis_tdata,   // [63:0] radicand
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [RootW-1:0]     m_axis_tdata    // [31:0] root
);

  localparam int unsigned RootBits = (WIDTH + 1) / 2;
  localparam int unsigned PadW     = 2 * RootBits;

  isr_fwd_t              fwd  [RootBits+1];
  isr_bwd_t              bwd  [RootBits+1];
  logic [PadW-1:0]       rad  [RootBits+1];
  logic [RootBits:0]     rem  [RootBits+1];
  logic [RootBits-1:0]   root [RootBits+1];

  // Feed the head of the chain with the zero-padded radicand
  assign fwd[0].valid = s_axis_tvalid;
  assign s_axis_tready = bwd[0].ready;
  assign rad[0]  = PadW'(s_axis_tdata[WIDTH-1:0]);
  assign rem[0]  = '0;
  assign root[0] = '0;

  for (genvar i = 0; i < RootBits; i++) begin : g_cell
    isr_cell #(
      .RootBits(RootBits)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .up_fwd_i(fwd[i]),
      .up_bwd_o(bwd[i]),
      .rad_i   (rad[i]),
      .rem_i   (rem[i]),
      .root_i  (root[i]),
      .dn_fwd_o(fwd[i+1]),
      .dn_bwd_i(bwd[i+1]),
      .rad_o   (rad[i+1]),
      .rem_o   (rem[i+1]),
      .root_o  (root[i+1])
    );
  end

  // Drive the output word from the last cell
  assign bwd[RootBits].ready = m_axis_tready;
  assign m_axis_tvalid       = fwd[RootBits].valid;
  assign m_axis_tdata        = RootW'(root[RootBits]);

`ifndef ASSERT_OFF
  // Final remainder never exceeds twice the root
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (rem[RootBits] <= {root[RootBits], 1'b0}))
    else $error("remainder exceeds 2*root at output");

  // All radicand bits are consumed by the end of the chain
  a_rad_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (rad[RootBits] == '0))
    else $error("unconsumed radicand bits at output");

  // Input only stalls when the output is stalled
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output backpressure");
`endif

endmodule

>>> sv/isr_cell.sv
// One root-bit decision: bring down two radicand bits, try root*4+1 against
// the partial remainder, keep the bit if it fits. Holds its word until the
// next cell takes it.
module isr_cell
  import isr_pkg::*;
#(
  parameter int unsigned RootBits = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  isr_fwd_t                up_fwd_i,
  output isr_bwd_t                up_bwd_o,
  input  logic [2*RootBits-1:0]   rad_i,
  input  logic [RootBits:0]       rem_i,
  input  logic [RootBits-1:0]     root_i,
  output isr_fwd_t                dn_fwd_o,
  input  isr_bwd_t                dn_bwd_i,
  output logic [2*RootBits-1:0]   rad_o,
  output logic [RootBits:0]       rem_o,
  output logic [RootBits-1:0]     root_o
);

  logic                    valid_q;
  logic                    advance;
  logic [RootBits+2:0]     rem_sh;
  logic [RootBits+2:0]     trial;
  logic                    fits;
  logic [RootBits+2:0]     diff;
  logic [RootBits:0]       root_sh;
  logic [2*RootBits+1:0]   rad_sh;
  logic [2*RootBits-1:0]   rad_d, rad_q;
  logic [RootBits:0]       rem_d, rem_q;
  logic [RootBits-1:0]     root_d, root_q;

  // Take a new word when empty or when the next cell drains this one
  assign advance        = !valid_q || dn_bwd_i.ready;
  assign up_bwd_o.ready = advance;

  // Trial subtract of (root << 2) | 1 from the shifted remainder
  assign rem_sh  = {rem_i, rad_i[2*RootBits-1 -: 2]};
  assign trial   = {1'b0, root_i, 2'b01};
  assign fits    = (rem_sh >= trial);
  assign diff    = rem_sh - trial;
  assign root_sh = {root_i, fits};
  assign rad_sh  = {rad_i, 2'b00};

  always_comb begin
    rad_d  = rad_sh[2*RootBits-1:0];
    root_d = root_sh[RootBits-1:0];
    if (fits) begin
      rem_d = diff[RootBits:0];
    end else begin
      rem_d = rem_sh[RootBits:0];
    end
  end

  // Clear valid under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance) begin
      valid_q <= up_fwd_i.valid;
    end
  end

  // Payload: load on advance only
  always_ff @(posedge clk_i) begin
    if (advance && up_fwd_i.valid) begin
      rad_q  <= rad_d;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign dn_fwd_o.valid = valid_q;
  assign rad_o          = rad_q;
  assign rem_o          = rem_q;
  assign root_o         = root_q;

endmodule

>>> test/tb.sv
module tb;
  import isr_pkg::*;

  localparam int unsigned Width       = 64;
  localparam int unsigned RootBits    = (Width + 1) / 2;
  localparam int unsigned IdlePercent = 28;
  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned DrainCycles = 2 * RootBits + 8;

  localparam logic [RadicandW-1:0] RadicandMask = {RadicandW{1'b1}} >> (RadicandW - Width);

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [RadicandW-1:0] s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [RootW-1:0]     m_axis_tdata;

  logic [RootW-1:0] expected_roots[$];
  int unsigned      error_count;
  int unsigned      stall_cycles;
  logic             running;
  logic             full_rate;

  integer_square_root_unit #(
    .WIDTH(Width)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Free-running clock, starting low so the first rising edge comes after time zero
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Floor square root, one trial bit at a time from the top
  function automatic logic [RootW-1:0] floor_sqrt(input logic [RadicandW-1:0] radicand);
    logic [RootW-1:0]     root;
    logic [RootW-1:0]     trial;
    logic [RadicandW-1:0] value;
    root  = '0;
    value = radicand & RadicandMask;
    for (int b = RootBits - 1; b >= 0; b--) begin
      trial = root | (RootW'(1) << b);
      if (RadicandW'(trial) * RadicandW'(trial) <= value) begin
        root = trial;
      end
    end
    return root;
  endfunction

  // Send one radicand word, with random idle cycles ahead of it outside full-rate stretches
  task automatic send_radicand(input logic [RadicandW-1:0] radicand);
    while (!full_rate && $urandom_range(0, 99) < IdlePercent) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= radicand;
    @(negedge clk_i);
    while (!s_axis_tready) begin
      @(negedge clk_i);
    end
    @(posedge clk_i);
    expected_roots.push_back(floor_sqrt(radicand));
  endtask

  // Random radicand from a mix of shapes that stress the bit decisions
  function automatic logic [RadicandW-1:0] pick_radicand();
    logic [RadicandW-1:0] value;
    logic [RadicandW-1:0] k;
    int unsigned          shape;
    int unsigned          shift;
    shape = $urandom_range(0, 99);
    shift = $urandom_range(0, RadicandW - 1);
    value = {$urandom, $urandom};
    k     = RadicandW'($urandom);
    if (shape < 30) begin
      return value;
    end else if (shape < 60) begin
      // Around a perfect square, including the one just below the next square
      case ($urandom_range(0, 3))
        0: return k * k - 1;
        1: return k * k;
        2: return k * k + 1;
        default: return k * k + 2 * k;
      endcase
    end else if (shape < 85) begin
      return value >> shift;
    end else if (shape < 93) begin
      return RadicandW'(1) << shift;
    end else begin
      return (RadicandW'(1) << shift) - 1;
    end
  endfunction

  task automatic test_edge_radicands();
    logic [RadicandW-1:0] max_root;
    max_root = RadicandW'({RootW{1'b1}});
    send_radicand('0);
    send_radicand(1);
    send_radicand(2);
    send_radicand(3);
    send_radicand(4);
    send_radicand(8);
    send_radicand(9);
    send_radicand(15);
    send_radicand(16);
    send_radicand({RadicandW{1'b1}});
    send_radicand(max_root * max_root);
    send_radicand(max_root * max_root - 1);
    send_radicand(max_root * max_root + 1);
    send_radicand(RadicandW'(1) << (RadicandW - 1));
    send_radicand(RadicandW'(1) << (RadicandW - 2));
    send_radicand((RadicandW'(1) << (RadicandW - 2)) - 1);
    send_radicand(RadicandW'(65536) * 65536);
    send_radicand(RadicandW'(65536) * 65536 - 1);
    send_radicand(64'hAAAA_AAAA_AAAA_AAAA);
    send_radicand(64'h5555_5555_5555_5555);
    send_radicand(64'h8000_0000_0000_0001);
  endtask

  task automatic test_random_radicands(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_radicand(pick_radicand());
    end
  endtask

  // Back-to-back words with the output always ready
  task automatic test_full_rate(input int unsigned count);
    full_rate = 1'b1;
    test_random_radicands(count);
    full_rate = 1'b0;
  endtask

  // Toggle output ready at random, except in full-rate stretches
  always @(posedge clk_i) begin
    if (running) begin
      m_axis_tready <= full_rate || ($urandom_range(0, 99) >= IdlePercent);
    end
  end

  // Compare each accepted root with the oldest expectation
  always @(negedge clk_i) begin
    if (running && m_axis_tvalid && m_axis_tready) begin
      if (expected_roots.size() == 0) begin
        $display("%0t: unexpected root word, expected none, actual %0d", $time,
                 m_axis_tdata);
        error_count++;
      end else begin
        if (m_axis_tdata !== expected_roots[0]) begin
          $display("%0t: root mismatch, expected %0d, actual %0d", $time,
                   expected_roots[0], m_axis_tdata);
          error_count++;
        end
        void'(expected_roots.pop_front());
      end
    end
  end

  // Abort when no word moves on either side for too long
  always @(negedge clk_i) begin
    if (running) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    error_count   = 0;
    stall_cycles  = 0;
    running       = 1'b0;
    full_rate     = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni  <= 1'b1;
    running <= 1'b1;
    @(posedge clk_i);

    test_edge_radicands();
    test_random_radicands(200);
    test_full_rate(200);
    test_random_radicands(200);

    // Drain the pipeline
    s_axis_tvalid <= 1'b0;
    while (expected_roots.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
